>>> design/nutf_pkg.sv
// ----------------------------------------------------------------------------
// nutf_pkg: shared types and constants of the NAL unit type filter
// Holds the command format that travels from the front to the back through
// the queue, the queue status type and the constants of the filter.
// ----------------------------------------------------------------------------
package nutf_pkg;

	localparam int MAX_RES = 5;
	localparam int CNT_W = 3;
	localparam logic [7:0] TYPE_MASK = 8'h1F;

	typedef struct packed {
		logic [CNT_W-1:0]           count;
		logic [MAX_RES-1:0][7:0]    bytes;
		logic                       bare;
		logic                       last;
		logic                       changed;
		logic                       cfg_err;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> design/nal_unit_type_filter_top.sv
// ----------------------------------------------------------------------------
// nal_unit_type_filter_top: H.264 Annex-B NAL unit type filter
// Removes whole NAL units by type from a byte stream, start codes included.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the queue has room and gives one
// result item per cycle while out_ready is high. Start-code bytes are held
// back until the type byte arrives, so that byte yields up to five result
// items at once; the output side drains them one a cycle while the command
// queue of QUEUE_DEPTH entries keeps the input open.
module nal_unit_type_filter_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_packet,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        last,
	output logic        changed,
	output logic        config_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	nutf_pkg::cmd_t      push_cmd;
	nutf_pkg::cmd_t      head;
	nutf_pkg::q_status_t q_status;
	logic                push;
	logic                pop;

	nutf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.end_of_packet (end_of_packet),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_status      (q_status),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	nutf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	nutf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.changed      (changed),
		.config_error (config_error)
	);

	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> last && out_byte == 8'd0)
		else $error("bare end item is not the last item of its packet");

	a_flags_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (changed || config_error) |-> last)
		else $error("packet flags raised on an item that is not last");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push || !in_ready)
		else $error("item accepted while the command queue is full");

endmodule

>>> design/nutf_front.sv
// ----------------------------------------------------------------------------
// nutf_front: start-code scanner and unit classifier
// Accepts one byte per cycle while the queue has room, tracks held-back start-code
// bytes, decides the fate of each NAL unit and builds a command of up to five result bytes.
// ----------------------------------------------------------------------------
module nutf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               end_of_packet,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  nutf_pkg::q_status_t q_status,
	output logic               push,
	output nutf_pkg::cmd_t     push_cmd
);

	localparam logic [1:0] PH_PRE   = 2'd0;
	localparam logic [1:0] PH_UNIT  = 2'd1;
	localparam logic [1:0] PH_AWAIT = 2'd2;

	localparam logic CFG_REMOVE = 1'b0;
	localparam logic CFG_KEEP   = 1'b1;

	logic [31:0] remove_mask_q;
	logic [31:0] keep_mask_q;
	logic [1:0]  phase_q;
	logic [2:0]  held_count_q;
	logic        dropping_q;
	logic        removed_q;

	logic [1:0]  phase_d;
	logic [2:0]  held_count_d;
	logic        dropping_d;
	logic        removed_d;
	nutf_pkg::cmd_t cmd;
	logic        cfg_err;
	logic [4:0]  nal_type;
	logic        drop_type;
	logic        cur_drop;
	logic        accept;

	function automatic nutf_pkg::cmd_t put(nutf_pkg::cmd_t c, logic drop, logic [7:0] v);
		nutf_pkg::cmd_t r;
		r = c;
		if (!drop && r.count < nutf_pkg::CNT_W'(nutf_pkg::MAX_RES)) begin
			r.bytes[r.count] = v;
			r.count = r.count + 1'b1;
		end
		return r;
	endfunction

	function automatic nutf_pkg::cmd_t flush(nutf_pkg::cmd_t c, logic [2:0] hc,
			logic ends_one, logic drop);
		nutf_pkg::cmd_t r;
		logic [7:0] v;
		r = c;
		for (int i = 0; i < 4; i++) begin
			v = (ends_one && 3'(i) == hc - 3'd1) ? 8'd1 : 8'd0;
			if (3'(i) < hc) r = put(r, drop, v);
		end
		return r;
	endfunction

	assign accept = in_valid && in_ready;
	assign in_ready = !q_status.full;
	assign cfg_ready = 1'b1;
	assign cfg_err = (remove_mask_q != 32'd0) && (keep_mask_q != 32'd0);
	assign nal_type = 5'(in_byte & nutf_pkg::TYPE_MASK);
	assign drop_type = !cfg_err && (remove_mask_q[nal_type] ||
		(keep_mask_q != 32'd0 && !keep_mask_q[nal_type]));

	always_comb begin
		cmd = '0;
		phase_d = phase_q;
		held_count_d = held_count_q;
		dropping_d = dropping_q;
		removed_d = removed_q;

		if (phase_q == PH_AWAIT) begin
			if (drop_type) removed_d = 1'b1;
			cmd = flush(cmd, held_count_d, 1'b1, drop_type);
			held_count_d = 3'd0;
			dropping_d = drop_type;
			phase_d = PH_UNIT;
		end

		cur_drop = (phase_d == PH_PRE) ? 1'b0 : dropping_d;
		if (in_byte == 8'd0) begin
			if (held_count_d >= 3'd3) begin
				cmd = put(cmd, cur_drop, 8'd0);
				held_count_d = 3'd2;
			end
			held_count_d = held_count_d + 3'd1;
		end else if (in_byte == 8'd1 && (held_count_d == 3'd2 || held_count_d == 3'd3)) begin
			held_count_d = held_count_d + 3'd1;
			phase_d = PH_AWAIT;
		end else begin
			cmd = flush(cmd, held_count_d, 1'b0, cur_drop);
			held_count_d = 3'd0;
			cmd = put(cmd, cur_drop, in_byte);
		end

		if (end_of_packet) begin
			if (phase_d == PH_AWAIT) cmd = flush(cmd, held_count_d, 1'b1, 1'b0);
			else cmd = flush(cmd, held_count_d, 1'b0, cur_drop);
			if (cmd.count == '0) begin
				cmd.count = nutf_pkg::CNT_W'(1);
				cmd.bare = 1'b1;
			end
			cmd.last = 1'b1;
			cmd.changed = removed_d;
			cmd.cfg_err = cfg_err;
			phase_d = PH_PRE;
			held_count_d = 3'd0;
			dropping_d = 1'b0;
			removed_d = 1'b0;
		end
	end

	assign push = accept && (cmd.count != '0);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE;
			held_count_q <= 3'd0;
			dropping_q <= 1'b0;
			removed_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_count_q <= held_count_d;
			dropping_q <= dropping_d;
			removed_q <= removed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remove_mask_q <= 32'd0;
			keep_mask_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REMOVE: remove_mask_q <= cfg_data;
				CFG_KEEP:   keep_mask_q <= cfg_data;
				default:    remove_mask_q <= remove_mask_q;
			endcase
		end
	end

endmodule

>>> design/nutf_queue.sv
// ----------------------------------------------------------------------------
// nutf_queue: command queue between front and back
// A small register queue that lets the scanner and the output side stall
// independently of each other.
// ----------------------------------------------------------------------------
module nutf_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  nutf_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output nutf_pkg::cmd_t      head,
	output nutf_pkg::q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	nutf_pkg::cmd_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop = pop && !status.empty;
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> design/nutf_back.sv
// ----------------------------------------------------------------------------
// nutf_back: result serializer
// Walks the bytes of the command at the head of the queue and presents one
// result item per cycle through an output register while out_ready is high.
// ----------------------------------------------------------------------------
module nutf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  nutf_pkg::cmd_t      head,
	input  nutf_pkg::q_status_t q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                byte_valid,
	output logic                last,
	output logic                changed,
	output logic                config_error
);

	logic [nutf_pkg::CNT_W-1:0] idx_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       byte_valid_q;
	logic                       last_q;
	logic                       changed_q;
	logic                       config_error_q;
	logic                       load;
	logic                       fin;

	assign load = !out_valid_q || out_ready;
	assign fin = (idx_q == head.count - 1'b1);
	assign pop = load && !q_status.empty && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			out_valid_q <= !q_status.empty;
			if (!q_status.empty) idx_q <= fin ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_status.empty) begin
			out_byte_q <= head.bare ? 8'd0 : head.bytes[idx_q];
			byte_valid_q <= !head.bare;
			last_q <= head.last && fin;
			changed_q <= head.changed && fin;
			config_error_q <= head.cfg_err && fin;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign last = last_q;
	assign changed = changed_q;
	assign config_error = config_error_q;

endmodule
